>>> rtl/core/knot_hash_engine_unit_macros.svh
// Assertion macros shared by the knot hash engine RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef KNOT_HASH_ENGINE_UNIT_MACROS_SVH
`define KNOT_HASH_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, quiet during reset
`define KHE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("knot hash engine: same-cycle check failed");

// Next-cycle implication, clocked on the rising edge, quiet during reset
`define KHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("knot hash engine: next-cycle check failed");

`endif

>>> rtl/core/khe_pkg.sv
// Shared constants, suffix table and controller/datapath interface types
// for the knot hash engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package khe_pkg;

   // Default sizes
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MAX_LENGTHS_DEF   = 64;
   localparam int ROUND_COUNT_DEF   = 64;

   // Field and datapath widths
   localparam int LEN_W      = 9;
   localparam int BYTE_W     = 8;
   localparam int VALUE_W    = 16;
   localparam int SWAP_W     = 8;
   localparam int SFX_W      = 3;
   localparam int BLK_W      = 4;
   localparam int DIDX_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Hash constants
   localparam int SUFFIX_COUNT = 5;
   localparam int DENSE_BLOCKS = 16;
   localparam int BLOCK_SIZE   = 16;

   // Mode register codes
   localparam logic MODE_FULL   = 1'b0;
   localparam logic MODE_SINGLE = 1'b1;

   // Register word index (paddr[2])
   localparam logic REG_MODE = 1'b0;

   // Fixed suffix appended to every round in full mode
   function automatic logic [LEN_W-1:0] suffix_len(input logic [SFX_W-1:0] idx);
      logic [LEN_W-1:0] len;
      case (idx)
         3'd0:    len = 9'd17;
         3'd1:    len = 9'd31;
         3'd2:    len = 9'd73;
         3'd3:    len = 9'd47;
         3'd4:    len = 9'd23;
         default: len = 9'd0;
      endcase
      return len;
   endfunction

   // Controller to datapath commands
   typedef struct packed {
      logic                   store;
      logic                   len_rd;
      logic                   len_latch;
      logic                   len_sfx;
      logic [SFX_W-1:0]       sfx_idx;
      logic                   setup;
      logic                   swap_rd;
      logic                   wr_a;
      logic                   wr_b;
      logic                   advance;
      logic                   dense_rd;
      logic [DIDX_W-1:0]      dense_idx;
      logic                   acc_load;
      logic                   acc_add;
      logic                   prod_rd;
      logic                   emit_dense;
      logic                   emit_prod;
      logic                   emit_final;
      logic                   clear;
   } khe_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic                   out_free;
      logic                   len_fits;
      logic [LEN_W-1:0]       cur_len;
   } khe_sts_type;

endpackage

`default_nettype wire

>>> rtl/core/khe_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module khe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_a_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_a_addr,
   output logic      [WIDTH-1:0]                       rd_a_data,
   input  wire logic                                   rd_b_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]                       rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port, read ports hold their data when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

>>> rtl/core/khe_datapath.sv
// Knot hash datapath: length store, ring table with valid bits, position and
// skip, swap pointers, dense-hash accumulator and result register.
// Depends on khe_pkg and khe_ram.
`timescale 1ns / 1ps
`default_nettype none

module khe_datapath #(
   parameter int TABLE_ENTRIES = khe_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_LENGTHS   = khe_pkg::MAX_LENGTHS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire khe_pkg::khe_cmd_type                  cmd,
   input  wire logic [((MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1)-1:0] len_idx,
   output khe_pkg::khe_sts_type                       sts,
   output logic [$clog2(MAX_LENGTHS+1)-1:0]           len_count,
   input  wire logic [khe_pkg::LEN_W-1:0]             req_length,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [khe_pkg::VALUE_W-1:0]                rsp_value,
   output logic                                       rsp_final_res
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int LS_AW   = (MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1;
   localparam int CNT_W   = $clog2(MAX_LENGTHS+1);
   localparam int LEN_W   = khe_pkg::LEN_W;
   localparam int BYTE_W  = khe_pkg::BYTE_W;
   localparam int VALUE_W = khe_pkg::VALUE_W;
   localparam int SUM_W   = LEN_W + 1;

   // message length store
   logic [CNT_W-1:0]  count_ff;
   logic [LEN_W-1:0]  ls_q;
   logic              ls_wr;
   logic [LEN_W-1:0]  cur_len_ff;

   // ring position and skip
   logic [IDX_W-1:0]  pos_ff;
   logic [7:0]        skip_ff;
   logic [IDX_W-1:0]  skip_mod_ff;
   logic [SUM_W-1:0]  adv_sum1;
   logic [SUM_W-1:0]  adv_red1;
   logic [SUM_W-1:0]  adv_sum2;
   logic [SUM_W-1:0]  adv_red2;
   logic [SUM_W-1:0]  b_sum;
   logic [SUM_W-1:0]  b_red;

   // table access
   logic [IDX_W-1:0]  a_ptr_ff;
   logic [IDX_W-1:0]  b_ptr_ff;
   logic [TABLE_ENTRIES-1:0] vld_ff;
   logic [IDX_W-1:0]  rd_a_addr;
   logic [IDX_W-1:0]  rd_b_addr;
   logic              rd_a_en;
   logic              rd_b_en;
   logic [IDX_W-1:0]  rd_a_idx_ff;
   logic [IDX_W-1:0]  rd_b_idx_ff;
   logic              rd_a_vld_ff;
   logic              rd_b_vld_ff;
   logic              rd_a_zero_ff;
   logic [BYTE_W-1:0] tbl_q_a;
   logic [BYTE_W-1:0] tbl_q_b;
   logic [BYTE_W-1:0] data_a;
   logic [BYTE_W-1:0] data_b;
   logic              tbl_wr;
   logic [IDX_W-1:0]  tbl_wr_addr;
   logic [BYTE_W-1:0] tbl_wr_data;

   // results
   logic [BYTE_W-1:0]  acc_ff;
   logic [VALUE_W-1:0] prod;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_final_ff;
   logic [VALUE_W-1:0] rsp_value_in;

   // length store RAM
   assign ls_wr = cmd.store && (count_ff < CNT_W'(MAX_LENGTHS));

   khe_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_LENGTHS)
   ) u_len_ram (
      .clock     (clock),
      .wr_en     (ls_wr),
      .wr_addr   (count_ff[LS_AW-1:0]),
      .wr_data   (req_length),
      .rd_a_en   (cmd.len_rd),
      .rd_a_addr (len_idx),
      .rd_a_data (ls_q),
      .rd_b_en   (1'b0),
      .rd_b_addr ('0),
      .rd_b_data ()
   );

   // first swap partner: (pos + len - 1) mod N, only used for len >= 2
   assign b_sum = SUM_W'(pos_ff) + SUM_W'(cur_len_ff) - SUM_W'(1);
   assign b_red = (b_sum >= SUM_W'(TABLE_ENTRIES)) ? (b_sum - SUM_W'(TABLE_ENTRIES)) : b_sum;

   // next position: (pos + len + skip) mod N, in two reduce steps
   assign adv_sum1 = SUM_W'(pos_ff) + SUM_W'(cur_len_ff);
   assign adv_red1 = (adv_sum1 >= SUM_W'(TABLE_ENTRIES)) ?
                     (adv_sum1 - SUM_W'(TABLE_ENTRIES)) : adv_sum1;
   assign adv_sum2 = adv_red1 + SUM_W'(skip_mod_ff);
   assign adv_red2 = (adv_sum2 >= SUM_W'(TABLE_ENTRIES)) ?
                     (adv_sum2 - SUM_W'(TABLE_ENTRIES)) : adv_sum2;

   // table read address select
   always_comb begin
      rd_a_addr = a_ptr_ff;
      rd_b_addr = b_ptr_ff;
      if (cmd.dense_rd) begin
         rd_a_addr = cmd.dense_idx[IDX_W-1:0];
      end else if (cmd.prod_rd) begin
         rd_a_addr = '0;
         rd_b_addr = IDX_W'(1);
      end
   end

   assign rd_a_en = cmd.swap_rd || cmd.dense_rd || cmd.prod_rd;
   assign rd_b_en = cmd.swap_rd || cmd.prod_rd;

   // swap writes: a takes old b, then b takes old a
   assign tbl_wr      = cmd.wr_a || cmd.wr_b;
   assign tbl_wr_addr = cmd.wr_a ? a_ptr_ff : b_ptr_ff;
   assign tbl_wr_data = cmd.wr_a ? data_b : data_a;

   khe_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ring_ram (
      .clock     (clock),
      .wr_en     (tbl_wr),
      .wr_addr   (tbl_wr_addr),
      .wr_data   (tbl_wr_data),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (tbl_q_a),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (tbl_q_b)
   );

   // unwritten entries read as their own index, out-of-table entries as zero
   assign data_a = rd_a_zero_ff ? '0 : (rd_a_vld_ff ? tbl_q_a : BYTE_W'(rd_a_idx_ff));
   assign data_b = rd_b_vld_ff ? tbl_q_b : BYTE_W'(rd_b_idx_ff);

   assign prod = VALUE_W'(data_a) * VALUE_W'(data_b);

   assign rsp_value_in = cmd.emit_dense ? VALUE_W'(acc_ff) : prod;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         skip_ff      <= '0;
         skip_mod_ff  <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff    <= '0;
            pos_ff      <= '0;
            skip_ff     <= '0;
            skip_mod_ff <= '0;
            vld_ff      <= '0;
         end else begin
            if (ls_wr) begin
               count_ff <= count_ff + CNT_W'(1);
            end
            if (cmd.advance) begin
               pos_ff  <= adv_red2[IDX_W-1:0];
               skip_ff <= skip_ff + 8'd1;
               // skip mod N follows skip, which itself wraps at 256
               if (skip_ff == 8'hFF) begin
                  skip_mod_ff <= '0;
               end else if (skip_mod_ff == IDX_W'(TABLE_ENTRIES-1)) begin
                  skip_mod_ff <= '0;
               end else begin
                  skip_mod_ff <= skip_mod_ff + IDX_W'(1);
               end
            end
            if (tbl_wr) begin
               vld_ff[tbl_wr_addr] <= 1'b1;
            end
         end
         // result register
         if (cmd.emit_dense || cmd.emit_prod) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.len_latch) begin
         cur_len_ff <= cmd.len_sfx ? khe_pkg::suffix_len(cmd.sfx_idx) : ls_q;
      end
      if (cmd.setup) begin
         a_ptr_ff <= pos_ff;
         b_ptr_ff <= b_red[IDX_W-1:0];
      end else if (cmd.wr_b) begin
         a_ptr_ff <= (a_ptr_ff == IDX_W'(TABLE_ENTRIES-1)) ? '0 : a_ptr_ff + IDX_W'(1);
         b_ptr_ff <= (b_ptr_ff == '0) ? IDX_W'(TABLE_ENTRIES-1) : b_ptr_ff - IDX_W'(1);
      end
      if (rd_a_en) begin
         rd_a_idx_ff  <= rd_a_addr;
         rd_a_vld_ff  <= vld_ff[rd_a_addr];
         rd_a_zero_ff <= cmd.dense_rd &&
                         (LEN_W'(cmd.dense_idx) >= LEN_W'(TABLE_ENTRIES));
      end
      if (rd_b_en) begin
         rd_b_idx_ff <= rd_b_addr;
         rd_b_vld_ff <= vld_ff[rd_b_addr];
      end
      if (cmd.acc_load) begin
         acc_ff <= data_a;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff ^ data_a;
      end
      if (cmd.emit_dense || cmd.emit_prod) begin
         rsp_value_ff <= rsp_value_in;
         rsp_final_ff <= cmd.emit_final;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign sts.len_fits = (cur_len_ff <= LEN_W'(TABLE_ENTRIES));
   assign sts.cur_len  = cur_len_ff;
   assign len_count    = count_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_final_res = rsp_final_ff;

endmodule

`default_nettype wire

>>> rtl/core/khe_ctrl.sv
// Knot hash controller: sequences length fetch, span reversal swaps, rounds,
// dense hash and result emission. Depends on khe_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "knot_hash_engine_unit_macros.svh"

module khe_ctrl #(
   parameter int MAX_LENGTHS = khe_pkg::MAX_LENGTHS_DEF,
   parameter int ROUND_COUNT = khe_pkg::ROUND_COUNT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  mode,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_last,
   output logic                                       req_stall,
   output khe_pkg::khe_cmd_type                       cmd,
   output logic [((MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1)-1:0] len_idx,
   input  wire khe_pkg::khe_sts_type                  sts,
   input  wire logic [$clog2(MAX_LENGTHS+1)-1:0]      len_count
);

   localparam int LS_AW  = (MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1;
   localparam int CNT_W  = $clog2(MAX_LENGTHS+1);
   localparam int RND_W  = $clog2(ROUND_COUNT+1);
   localparam int SFX_W  = khe_pkg::SFX_W;
   localparam int BLK_W  = khe_pkg::BLK_W;
   localparam int SWAP_W = khe_pkg::SWAP_W;
   localparam int LEN_W  = khe_pkg::LEN_W;

   typedef enum logic [3:0] {
      IDLE,
      LEN_RD,
      LEN_LATCH,
      SETUP,
      SW_RD,
      SW_WA,
      SW_WB,
      ADVANCE,
      D_RD,
      D_ACC,
      EMIT,
      P_RD,
      P_EMIT,
      CLEAR
   } state_type;

   state_type          state_ff;
   logic               stall_ff;
   logic [CNT_W-1:0]   li_ff;
   logic [SFX_W-1:0]   sfx_ff;
   logic [SFX_W-1:0]   sel_ff;
   logic               src_sfx_ff;
   logic [RND_W-1:0]   round_ff;
   logic [SWAP_W-1:0]  swaps_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [BLK_W-1:0]   j_ff;
   logic               accept;
   logic               have_len;
   logic               have_sfx;
   logic [SWAP_W-1:0]  half_len;

   assign accept   = req_valid && !stall_ff;
   assign have_len = (li_ff < len_count);
   assign have_sfx = (mode == khe_pkg::MODE_FULL) && (sfx_ff < SFX_W'(khe_pkg::SUFFIX_COUNT));
   assign half_len = sts.cur_len[LEN_W-1:1];

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.store      = accept;
      cmd.len_sfx    = src_sfx_ff;
      cmd.sfx_idx    = sel_ff;
      cmd.dense_idx  = {blk_ff, j_ff};
      cmd.emit_final = 1'b0;
      unique case (state_ff)
         IDLE:      cmd.store     = accept;
         LEN_RD:    cmd.len_rd    = have_len;
         LEN_LATCH: cmd.len_latch = 1'b1;
         SETUP:     cmd.setup     = 1'b1;
         SW_RD:     cmd.swap_rd   = 1'b1;
         SW_WA:     cmd.wr_a      = 1'b1;
         SW_WB:     cmd.wr_b      = 1'b1;
         ADVANCE:   cmd.advance   = 1'b1;
         D_RD:      cmd.dense_rd  = 1'b1;
         D_ACC: begin
            cmd.acc_load = (j_ff == '0);
            cmd.acc_add  = (j_ff != '0);
         end
         EMIT: begin
            cmd.emit_dense = sts.out_free;
            cmd.emit_final = (blk_ff == BLK_W'(khe_pkg::DENSE_BLOCKS-1));
         end
         P_RD:      cmd.prod_rd   = 1'b1;
         P_EMIT: begin
            cmd.emit_prod  = sts.out_free;
            cmd.emit_final = 1'b1;
         end
         CLEAR:     cmd.clear     = 1'b1;
         default:   cmd           = '0;
      endcase
      if (state_ff != IDLE) begin
         cmd.store = 1'b0;
      end
   end

   assign len_idx = li_ff[LS_AW-1:0];

   // state, counters and stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         stall_ff   <= 1'b0;
         li_ff      <= '0;
         sfx_ff     <= '0;
         sel_ff     <= '0;
         src_sfx_ff <= 1'b0;
         round_ff   <= '0;
         swaps_ff   <= '0;
         blk_ff     <= '0;
         j_ff       <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (accept && req_last) begin
                  stall_ff <= 1'b1;
                  li_ff    <= '0;
                  sfx_ff   <= '0;
                  round_ff <= '0;
                  state_ff <= LEN_RD;
               end
            end
            // pick the next length: stored ones, then the suffix
            LEN_RD: begin
               if (have_len) begin
                  li_ff      <= li_ff + CNT_W'(1);
                  src_sfx_ff <= 1'b0;
                  state_ff   <= LEN_LATCH;
               end else if (have_sfx) begin
                  sel_ff     <= sfx_ff;
                  sfx_ff     <= sfx_ff + SFX_W'(1);
                  src_sfx_ff <= 1'b1;
                  state_ff   <= LEN_LATCH;
               end else begin
                  li_ff    <= '0;
                  sfx_ff   <= '0;
                  round_ff <= round_ff + RND_W'(1);
                  if (mode == khe_pkg::MODE_SINGLE) begin
                     state_ff <= P_RD;
                  end else if (round_ff == RND_W'(ROUND_COUNT-1)) begin
                     blk_ff   <= '0;
                     j_ff     <= '0;
                     state_ff <= D_RD;
                  end
               end
            end
            LEN_LATCH: state_ff <= SETUP;
            SETUP: begin
               swaps_ff <= half_len;
               if (!sts.len_fits) begin
                  state_ff <= LEN_RD;
               end else if (half_len == '0) begin
                  state_ff <= ADVANCE;
               end else begin
                  state_ff <= SW_RD;
               end
            end
            SW_RD: state_ff <= SW_WA;
            SW_WA: state_ff <= SW_WB;
            SW_WB: begin
               swaps_ff <= swaps_ff - SWAP_W'(1);
               state_ff <= (swaps_ff == SWAP_W'(1)) ? ADVANCE : SW_RD;
            end
            ADVANCE: state_ff <= LEN_RD;
            // dense hash: each entry is read in D_RD and folded in D_ACC
            D_RD: state_ff <= D_ACC;
            D_ACC: begin
               if (j_ff == BLK_W'(khe_pkg::BLOCK_SIZE-1)) begin
                  state_ff <= EMIT;
               end else begin
                  j_ff     <= j_ff + BLK_W'(1);
                  state_ff <= D_RD;
               end
            end
            EMIT: begin
               if (sts.out_free) begin
                  if (blk_ff == BLK_W'(khe_pkg::DENSE_BLOCKS-1)) begin
                     state_ff <= CLEAR;
                  end else begin
                     blk_ff   <= blk_ff + BLK_W'(1);
                     j_ff     <= '0;
                     state_ff <= D_RD;
                  end
               end
            end
            P_RD: state_ff <= P_EMIT;
            P_EMIT: begin
               if (sts.out_free) begin
                  state_ff <= CLEAR;
               end
            end
            CLEAR: begin
               stall_ff <= 1'b0;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall = stall_ff;

   // checks
   `KHE_ASSERT_NEXT(a_last_closes_input, clock, reset, req_valid && !stall_ff && req_last, stall_ff)
   `KHE_ASSERT_NOW(a_swap_count_live, clock, reset, state_ff == SW_RD, swaps_ff != '0)
   `KHE_ASSERT_NOW(a_emit_into_free, clock, reset, cmd.emit_dense || cmd.emit_prod, sts.out_free)
   `KHE_ASSERT_NOW(a_len_idx_bound, clock, reset, state_ff == LEN_RD, li_ff <= len_count)

endmodule

`default_nettype wire

>>> rtl/core/knot_hash_engine_unit.sv
// Knot hash engine top level: mode register on the APB-style port, controller
// and datapath. Depends on khe_pkg, khe_ctrl, khe_datapath (and khe_ram).
//
//   port group | direction | transfer when         | payload
//   req_       | in        | req_valid & !stall   | length (9), last (1)
//   rsp_       | out       | rsp_valid & !stall   | value (16), final_res (1)
//   csr_       | in/out    | psel&penable&pwrite  | mode at byte address 0
//
// A non-last length is taken when offered; a last one holds req_stall high
// through the rounds, results and table restore: a length L <= TABLE_ENTRIES
// passes LEN_RD, LEN_LATCH, SETUP, floor(L/2) swaps and ADVANCE, an oversized
// one stops after SETUP, each round ends in a LEN_RD; the ring table's single
// write port splits a swap into SW_RD, SW_WA, SW_WB; CLEAR restores the table.
// Reset is synchronous and needs no clearing pass; rsp_stall only holds the
// one-deep result register, results are never dropped.
`timescale 1ns / 1ps
`default_nettype none

module knot_hash_engine_unit #(
   parameter int TABLE_ENTRIES = khe_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_LENGTHS   = khe_pkg::MAX_LENGTHS_DEF,
   parameter int ROUND_COUNT   = khe_pkg::ROUND_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [khe_pkg::LEN_W-1:0]         req_length,
   input  wire logic                              req_last,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [khe_pkg::VALUE_W-1:0]            rsp_value,
   output logic                                   rsp_final_res,
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [khe_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [khe_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [khe_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   localparam int LS_AW = (MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1;
   localparam int CNT_W = $clog2(MAX_LENGTHS+1);

   logic                  mode_ff;
   logic                  csr_wr;
   khe_pkg::khe_cmd_type  cmd;
   khe_pkg::khe_sts_type  sts;
   logic [LS_AW-1:0]      len_idx;
   logic [CNT_W-1:0]      len_count;

   // mode register, written in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= khe_pkg::MODE_FULL;
      end else if (csr_wr && (csr_paddr[2] == khe_pkg::REG_MODE)) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == khe_pkg::REG_MODE) ?
                       khe_pkg::CSR_DATA_W'(mode_ff) : '0;

   khe_ctrl #(
      .MAX_LENGTHS (MAX_LENGTHS),
      .ROUND_COUNT (ROUND_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .cmd       (cmd),
      .len_idx   (len_idx),
      .sts       (sts),
      .len_count (len_count)
   );

   khe_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_LENGTHS   (MAX_LENGTHS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .len_idx       (len_idx),
      .sts           (sts),
      .len_count     (len_count),
      .req_length    (req_length),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_final_res (rsp_final_res)
   );

endmodule

`default_nettype wire

>>> verif/tb_knot_hash_engine_unit.sv
// Self-checking testbench for knot_hash_engine_unit: drives span-length messages,
// sets the mode over the APB-style port and checks every result transfer.
// Depends on khe_pkg and the knot_hash_engine_unit RTL only.
`timescale 1ns / 1ps

module tb_knot_hash_engine_unit;
   import khe_pkg::*;

   localparam int RING_ENTRIES  = TABLE_ENTRIES_DEF;
   localparam int MAX_SPANS     = MAX_LENGTHS_DEF;
   localparam int ROUNDS        = ROUND_COUNT_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 64;
   localparam int HOLD_CYCLES   = 3000;
   localparam int PHASE_ITEMS   = 16;
   localparam int FLOOD_ITEMS   = 66;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               final_res;
   } knot_result_type;

   // Scoreboard: tracks the ring and span store, predicts digests, checks results
   class knot_hash_checker;
      logic [BYTE_W-1:0] ring [RING_ENTRIES];
      logic [LEN_W-1:0]  spans [MAX_SPANS];
      int                suffix_spans [SUFFIX_COUNT] = '{17, 31, 73, 47, 23};
      int unsigned       span_count;
      int unsigned       pos;
      int unsigned       skip;
      logic              mode = MODE_FULL;
      knot_result_type   pending [$];
      int                mismatches;

      function void restart();
         for (int i = 0; i < RING_ENTRIES; i++) ring[i] = BYTE_W'(i);
         span_count = 0;
         pos        = 0;
         skip       = 0;
      endfunction

      // Reverse one circular span, then step the position and skip
      function void twist(int unsigned len);
         int unsigned a;
         int unsigned b;
         logic [BYTE_W-1:0] swap;
         if (len > RING_ENTRIES) return;
         for (int unsigned k = 0; k < len / 2; k++) begin
            a       = (pos + k) % RING_ENTRIES;
            b       = (pos + len - 1 - k) % RING_ENTRIES;
            swap    = ring[a];
            ring[a] = ring[b];
            ring[b] = swap;
         end
         pos  = (pos + len + skip) % RING_ENTRIES;
         skip = (skip + 1) % 256;
      endfunction

      function void run_round(bit with_suffix);
         for (int i = 0; i < span_count; i++) twist(spans[i]);
         if (with_suffix)
            for (int s = 0; s < SUFFIX_COUNT; s++) twist(suffix_spans[s]);
      endfunction

      // Note an accepted length; a closing one yields the expected digest
      function void take_length(logic [LEN_W-1:0] len, logic last);
         knot_result_type   want;
         logic [BYTE_W-1:0] folded;
         if (span_count < MAX_SPANS) begin
            spans[span_count] = len;
            span_count++;
         end
         if (!last) return;
         if (mode == MODE_FULL) begin
            for (int rnd = 0; rnd < ROUNDS; rnd++) run_round(1'b1);
            for (int blk = 0; blk < DENSE_BLOCKS; blk++) begin
               folded = '0;
               for (int j = 0; j < BLOCK_SIZE; j++) folded ^= ring[blk * BLOCK_SIZE + j];
               want.value     = {8'h00, folded};
               want.final_res = (blk == DENSE_BLOCKS - 1);
               pending.insert(pending.size(), want);
            end
         end else begin
            run_round(1'b0);
            want.value     = VALUE_W'(ring[0]) * VALUE_W'(ring[1]);
            want.final_res = 1'b1;
            pending.insert(pending.size(), want);
         end
         restart();
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(input logic [VALUE_W-1:0] value, input logic fin);
         knot_result_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d final=%0b", value, fin));
            return;
         end
         want = pending.pop_front();
         if (value !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d", value, want.value));
         if (fin !== want.final_res)
            report_mismatch($sformatf("final flag %0b, expected %0b", fin, want.final_res));
      endtask
   endclass

   // Clock, reset and block inputs, all known from time zero
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [LEN_W-1:0]      req_length    = '0;
   logic                  req_last      = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic                  rsp_final_res;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   knot_hash_checker hash_check = new;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold      = 1'b0;
   bit   hold_arm      = 1'b0;
   int   items_sent    = 0;
   int   send_plan [4] = '{0, 83, 0, 13};
   int   stall_plan [4] = '{0, 0, 83, 13};

   knot_hash_engine_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_length    (req_length),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_final_res (rsp_final_res),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #2 clock = ~clock;

   // Result side: check each transfer, then pick the next stall
   always @(posedge clock) begin : result_sink
      if (!reset && rsp_valid && !rsp_stall)
         hash_check.check_result(rsp_value, rsp_final_res);
      rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
   end

   // Long receiver hold-off, counted here once armed
   initial begin : rsp_hold_off
      wait (hold_arm);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog
   initial begin : watchdog
      #(100_000_000);
      $display("FAILURE");
      $finish;
   end

   // One APB transfer: setup cycle, access cycle, then the bus returns to idle
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_mode_readback();
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, MODE_ADDR, '0, readback);
      if (readback !== CSR_DATA_W'(hash_check.mode))
         hash_check.report_mismatch($sformatf("mode reads %0h, expected %0b",
                                              readback, hash_check.mode));
   endtask

   // Wait for every outstanding result plus the table restore
   task automatic settle();
      req_valid <= 1'b0;
      while (hash_check.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      logic [CSR_DATA_W-1:0] unused;
      settle();
      csr_access(1'b1, MODE_ADDR, CSR_DATA_W'(m), unused);
      hash_check.mode = m;
      check_mode_readback();
   endtask

   // Offer one length, with random gaps, until the transfer happens
   task automatic push_length(input logic [LEN_W-1:0] len, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_length <= len;
      req_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hash_check.take_length(len, last);
      items_sent++;
   endtask

   // Full mode runs 64 rounds, so long spans stay rare and at most one per message
   function automatic logic [LEN_W-1:0] pick_span(inout bit long_used);
      if (hash_check.mode == MODE_SINGLE)
         return $urandom_range(1) ? LEN_W'($urandom_range(511)) : LEN_W'($urandom_range(31));
      if (!long_used && $urandom_range(9) == 0) begin
         long_used = 1'b1;
         return LEN_W'($urandom_range(511));
      end
      return LEN_W'($urandom_range(31));
   endfunction

   task automatic send_random_message(input int count);
      bit long_used;
      long_used = 1'b0;
      for (int i = 0; i < count; i++) push_length(pick_span(long_used), i == count - 1);
   endtask

   task automatic send_fixed(input int spans [$]);
      foreach (spans[i]) push_length(LEN_W'(spans[i]), i == spans.size() - 1);
   endtask

   initial begin : stimulus
      int   phase_end;
      logic want_mode;
      hash_check.restart();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_mode_readback();

      // Directed: full mode, a lone zero, then oversized and full-ring spans mixed in
      send_fixed('{0});
      send_fixed('{3, 4, 1, 256, 511, 5});
      // Directed: single round, the field extremes and the classic short message
      set_mode(MODE_SINGLE);
      send_fixed('{0, 1, 255, 256, 257, 511});
      send_fixed('{256});
      send_fixed('{2});
      send_fixed('{3, 4, 1, 5});

      // Overfill the span store; the closing length lands after the drop point
      send_random_message(FLOOD_ITEMS);

      // Receiver holds off while the sender keeps offering messages
      hold_arm = 1'b1;
      for (int m = 0; m < 4; m++) send_random_message($urandom_range(2, 5));

      // Random messages under each idling pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_plan[p];
         rsp_stall_pct <= stall_plan[p];
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            want_mode = ($urandom_range(3) == 0) ? MODE_FULL : MODE_SINGLE;
            if (want_mode != hash_check.mode) set_mode(want_mode);
            send_random_message($urandom_range(1, 8));
         end
      end

      req_valid <= 1'b0;
      while (hash_check.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hash_check.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
